[rtl/csr_gei_pkg.sv]
// shared command, status and state codes for the csr graph edge insert core
package csr_gei_pkg;

  typedef enum logic [2:0] {
    CMD_CLEAR      = 3'd0,
    CMD_ADD_VERTEX = 3'd1,
    CMD_ADD_EDGE   = 3'd2,
    CMD_READ_OFF   = 3'd3,
    CMD_READ_EDGE  = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    STS_OK    = 2'd0,
    STS_RANGE = 2'd1,
    STS_FULL  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    ST_CLR,
    ST_IDLE,
    ST_RD,
    ST_SHIFT,
    ST_INC,
    ST_FIN
  } state_t;

  localparam int TARGET_BITS = 8;

endpackage

[rtl/csr_gei_offset_mem.sv]
// row offset table memory, one write and one registered read per cycle
module csr_gei_offset_mem import csr_gei_pkg::*; #(
  parameter int DEPTH = 257,
  parameter int WIDTH = 11
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/csr_gei_edge_mem.sv]
// edge target and weight store, one write and one registered read per cycle
module csr_gei_edge_mem import csr_gei_pkg::*; #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 40
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/csr_graph_edge_insert_core.sv]
// csr graph edge insert core: command sequencer around offset and edge memories
//
// channel  direction  handshake            payload
// in       input      in_valid / in_stall  command, source_vertex, target_vertex,
//                                          edge_weight_in, edge_slot, new_vertex_total
// out      output     out_valid / out_stall status, added_vertex_index, row_offset,
//                                          edge_target_out, edge_weight_out,
//                                          vertex_total, edge_total
//
// one request at a time; add vertex and rejected requests go straight from idle to finish;
// reads pass through the read state first; add edge reads the insert offset, then moves
// each later edge up one slot, one edge per cycle, then bumps each later offset entry by one
// clear zeroes offset entries 0 through new_vertex_total, one offset entry zeroed per cycle
// after reset a one-entry clearing pass runs before the first request is taken
// a stalled result waits in the output register; the next request is still accepted
module csr_graph_edge_insert_core import csr_gei_pkg::*; #(
  parameter int MAX_VERTICES = 256,
  parameter int MAX_EDGES    = 1024,
  parameter int WEIGHT_BITS  = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         command,
  input  logic [8:0]         source_vertex,
  input  logic [7:0]         target_vertex,
  input  logic signed [31:0] edge_weight_in,
  input  logic [9:0]         edge_slot,
  input  logic [8:0]         new_vertex_total,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         status,
  output logic [7:0]         added_vertex_index,
  output logic [10:0]        row_offset,
  output logic [7:0]         edge_target_out,
  output logic signed [31:0] edge_weight_out,
  output logic [8:0]         vertex_total,
  output logic [10:0]        edge_total
);

  localparam int OI_W = $clog2(MAX_VERTICES + 1);
  localparam int VC_W = $clog2(MAX_VERTICES + 2);
  localparam int EI_W = $clog2(MAX_EDGES);
  localparam int EC_W = $clog2(MAX_EDGES + 1);
  localparam int EW_W = TARGET_BITS + WEIGHT_BITS;

  state_t state, state_next;

  logic [OI_W-1:0]        vc;
  logic [EC_W-1:0]        ecount;
  logic [VC_W-1:0]        curv;
  logic [VC_W-1:0]        clr_lim;
  logic                   init;
  logic [EC_W-1:0]        cur;
  logic [EC_W-1:0]        kpos;
  logic                   wr_pend;
  logic [EI_W-1:0]        ewaddr;
  logic [OI_W-1:0]        owaddr;
  cmd_t                   cmd;
  logic [EW_W-1:0]        new_edge;

  logic [1:0]             res_status;
  logic [7:0]             res_added;
  logic [10:0]            res_roff;
  logic [7:0]             res_tgt;
  logic [31:0]            res_wt;

  logic                   in_acc;
  logic                   out_free;

  logic                   off_we;
  logic [OI_W-1:0]        off_waddr;
  logic [EC_W-1:0]        off_wdata;
  logic [OI_W-1:0]        off_raddr;
  logic [EC_W-1:0]        off_rdata;
  logic                   e_we;
  logic [EI_W-1:0]        e_waddr;
  logic [EW_W-1:0]        e_wdata;
  logic [EI_W-1:0]        e_raddr;
  logic [EW_W-1:0]        e_rdata;

  logic                   src_ok_edge;
  logic                   dst_ok;
  logic                   shift_more;
  logic                   inc_more;

  assign in_stall = (state != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  assign src_ok_edge = 32'(source_vertex) < 32'(vc);
  assign dst_ok      = 32'(target_vertex) < 32'(vc);
  assign shift_more  = cur > kpos;
  assign inc_more    = curv <= VC_W'(vc);

  csr_gei_offset_mem #(.DEPTH(MAX_VERTICES + 1), .WIDTH(EC_W)) u_off (
    .clk   (clk),
    .we    (off_we),
    .waddr (off_waddr),
    .wdata (off_wdata),
    .raddr (off_raddr),
    .rdata (off_rdata)
  );

  csr_gei_edge_mem #(.DEPTH(MAX_EDGES), .WIDTH(EW_W)) u_edge (
    .clk   (clk),
    .we    (e_we),
    .waddr (e_waddr),
    .wdata (e_wdata),
    .raddr (e_raddr),
    .rdata (e_rdata)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLR: begin
        if (curv == clr_lim) begin
          state_next = init ? ST_IDLE : ST_FIN;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          unique case (command)
            CMD_CLEAR: begin
              state_next = (32'(new_vertex_total) > MAX_VERTICES) ? ST_FIN : ST_CLR;
            end
            CMD_ADD_EDGE: begin
              if (!src_ok_edge || !dst_ok || 32'(ecount) >= MAX_EDGES) begin
                state_next = ST_FIN;
              end else begin
                state_next = ST_RD;
              end
            end
            CMD_READ_OFF: begin
              state_next = (32'(source_vertex) > 32'(vc)) ? ST_FIN : ST_RD;
            end
            CMD_READ_EDGE: begin
              state_next = (32'(edge_slot) >= 32'(ecount)) ? ST_FIN : ST_RD;
            end
            default: state_next = ST_FIN;
          endcase
        end
      end
      ST_RD:    state_next = (cmd == CMD_ADD_EDGE) ? ST_SHIFT : ST_FIN;
      ST_SHIFT: begin
        if (!shift_more && !wr_pend) begin
          state_next = ST_INC;
        end
      end
      ST_INC: begin
        if (!inc_more && !wr_pend) begin
          state_next = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // memory controls
  always_comb begin
    off_we    = 1'b0;
    off_waddr = '0;
    off_wdata = '0;
    off_raddr = '0;
    e_we      = 1'b0;
    e_waddr   = '0;
    e_wdata   = new_edge;
    e_raddr   = '0;
    unique case (state)
      ST_CLR: begin
        off_we    = 1'b1;
        off_waddr = curv[OI_W-1:0];
      end
      ST_IDLE: begin
        off_raddr = source_vertex[OI_W-1:0];
        e_raddr   = edge_slot[EI_W-1:0];
        // add vertex: new closing entry copies the current edge total
        if (in_acc && command == CMD_ADD_VERTEX && 32'(vc) < MAX_VERTICES) begin
          off_we    = 1'b1;
          off_waddr = OI_W'(vc + 1'b1);
          off_wdata = ecount;
        end
      end
      ST_SHIFT: begin
        e_raddr = EI_W'(cur - 1'b1);
        if (wr_pend) begin
          e_we    = 1'b1;
          e_waddr = ewaddr;
          e_wdata = e_rdata;
        end else if (!shift_more) begin
          e_we    = 1'b1;
          e_waddr = kpos[EI_W-1:0];
        end
      end
      ST_INC: begin
        off_raddr = curv[OI_W-1:0];
        off_we    = wr_pend;
        off_waddr = owaddr;
        off_wdata = off_rdata + 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLR;
      init      <= 1'b1;
      vc        <= '0;
      ecount    <= '0;
      curv      <= '0;
      clr_lim   <= '0;
      wr_pend   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_CLR: begin
          if (curv == clr_lim) begin
            init <= 1'b0;
          end else begin
            curv <= curv + 1'b1;
          end
        end
        ST_IDLE: begin
          if (in_acc) begin
            cmd        <= cmd_t'(command);
            new_edge   <= {target_vertex, WEIGHT_BITS'(edge_weight_in)};
            res_status <= STS_OK;
            res_added  <= '0;
            res_roff   <= '0;
            res_tgt    <= '0;
            res_wt     <= '0;
            curv       <= VC_W'(source_vertex) + 1'b1;
            unique case (command)
              CMD_CLEAR: begin
                if (32'(new_vertex_total) > MAX_VERTICES) begin
                  res_status <= STS_RANGE;
                end else begin
                  vc      <= OI_W'(new_vertex_total);
                  ecount  <= '0;
                  curv    <= '0;
                  clr_lim <= VC_W'(new_vertex_total);
                end
              end
              CMD_ADD_VERTEX: begin
                if (32'(vc) >= MAX_VERTICES) begin
                  res_status <= STS_FULL;
                end else begin
                  res_added <= 8'(vc);
                  vc        <= vc + 1'b1;
                end
              end
              CMD_ADD_EDGE: begin
                if (!src_ok_edge || !dst_ok) begin
                  res_status <= STS_RANGE;
                end else if (32'(ecount) >= MAX_EDGES) begin
                  res_status <= STS_FULL;
                end
              end
              CMD_READ_OFF: begin
                if (32'(source_vertex) > 32'(vc)) begin
                  res_status <= STS_RANGE;
                end
              end
              CMD_READ_EDGE: begin
                if (32'(edge_slot) >= 32'(ecount)) begin
                  res_status <= STS_RANGE;
                end
              end
              default: res_status <= STS_RANGE;
            endcase
          end
        end
        ST_RD: begin
          kpos    <= off_rdata;
          cur     <= ecount;
          wr_pend <= 1'b0;
          if (cmd == CMD_READ_OFF) begin
            res_roff <= 11'(off_rdata);
          end
          if (cmd == CMD_READ_EDGE) begin
            res_tgt <= e_rdata[EW_W-1 -: TARGET_BITS];
            res_wt  <= 32'($signed(e_rdata[WEIGHT_BITS-1:0]));
          end
        end
        ST_SHIFT: begin
          // move one edge up per cycle, read one below, write on the next cycle
          if (shift_more) begin
            cur     <= cur - 1'b1;
            wr_pend <= 1'b1;
            ewaddr  <= cur[EI_W-1:0];
          end else begin
            wr_pend <= 1'b0;
          end
        end
        ST_INC: begin
          if (inc_more) begin
            curv    <= curv + 1'b1;
            wr_pend <= 1'b1;
            owaddr  <= curv[OI_W-1:0];
          end else begin
            wr_pend <= 1'b0;
            if (!wr_pend) begin
              ecount <= ecount + 1'b1;
            end
          end
        end
        ST_FIN: begin
          if (out_free) begin
            out_valid          <= 1'b1;
            status             <= res_status;
            added_vertex_index <= res_added;
            row_offset         <= res_roff;
            edge_target_out    <= res_tgt;
            edge_weight_out    <= res_wt;
            vertex_total       <= 9'(vc);
            edge_total         <= 11'(ecount);
          end
        end
        default: begin
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_vc_range: assert property (@(posedge clk) disable iff (rst) 32'(vc) <= MAX_VERTICES)
    else $error("vertex count beyond table size");
  a_ec_range: assert property (@(posedge clk) disable iff (rst) 32'(ecount) <= MAX_EDGES)
    else $error("edge count beyond store size");
  a_shift_ptr: assert property (@(posedge clk) disable iff (rst)
    state == ST_SHIFT |-> cur >= kpos)
    else $error("shift pointer below insert slot");
  a_inc_addr: assert property (@(posedge clk) disable iff (rst)
    (state == ST_INC && wr_pend) |-> 32'(owaddr) <= 32'(vc))
    else $error("offset increment past closing entry");
`endif

endmodule
